### rtl/dhci_pkg.sv
// shared types and constants for the deflate hash chain insert unit
// no dependencies
package dhci_pkg;

  localparam int FIELD_W = 15;

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [7:0]         byte_t;
  typedef logic [23:0]        history_t;
  typedef logic [31:0]        word_t;
  typedef logic [3:0]         hw_t;
  typedef logic [1:0]         seen_t;

  // multiplicative hash constant
  localparam word_t HASH_MULT = 32'h1E35A7BD;

  localparam hw_t   HW_MIN   = 4'd8;
  localparam hw_t   HW_RESET = 4'd15;
  localparam seen_t SEEN_FULL = 2'd3;

endpackage

### rtl/dhci_in_if.sv
// input channel of the hash chain insert unit: one byte per item
// depends on dhci_pkg
interface dhci_in_if;
  logic             valid;
  logic             ready;
  dhci_pkg::byte_t  data_byte;
  logic             start_of_buffer;

  modport source (output valid, output data_byte, output start_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input start_of_buffer, output ready);
endinterface

### rtl/dhci_out_if.sv
// result channel of the hash chain insert unit: one insertion per item
// depends on dhci_pkg
interface dhci_out_if;
  logic             valid;
  logic             ready;
  dhci_pkg::field_t position;
  dhci_pkg::field_t hash_value;
  dhci_pkg::field_t prior_head;

  modport source (output valid, output position, output hash_value, output prior_head,
                  input ready);
  modport sink   (input valid, input position, input hash_value, input prior_head,
                  output ready);
endinterface

### rtl/dhci_front.sv
// byte history, window position and hash multiply ahead of the head lookup
// depends on dhci_pkg and dhci_in_if
module dhci_front #(
  parameter int WINDOW_BITS = 15
) (
  input  logic                   clk,
  input  logic                   rst_n,
  dhci_in_if.sink                in_if,
  input  logic                   s1_take,
  input  logic                   s1_block,
  output logic                   s1_valid,
  output dhci_pkg::word_t        s1_prod,
  output logic [WINDOW_BITS-1:0] s1_pos
);

  dhci_pkg::history_t     hist_r, hist_nxt;
  dhci_pkg::seen_t        seen_r, seen_nxt;
  logic [WINDOW_BITS-1:0] npos_r, npos_nxt;
  logic                   s1_v_r, s1_v_nxt;
  dhci_pkg::word_t        prod_r;
  logic [WINDOW_BITS-1:0] pos_r;
  dhci_pkg::word_t        word;
  logic                   accept;
  logic                   insert;

  assign in_if.ready = !s1_block && (!s1_v_r || s1_take);
  assign accept      = in_if.valid && in_if.ready;
  assign word        = {in_if.data_byte, hist_r};
  assign insert      = accept && !in_if.start_of_buffer && (seen_r == dhci_pkg::SEEN_FULL);

  always_comb begin
    hist_nxt = hist_r;
    seen_nxt = seen_r;
    npos_nxt = npos_r;
    if (accept) begin
      if (in_if.start_of_buffer) begin
        hist_nxt = {in_if.data_byte, 16'h0000};
        seen_nxt = 2'd1;
        npos_nxt = '0;
      end else begin
        hist_nxt = word[31:8];
        if (seen_r != dhci_pkg::SEEN_FULL) begin
          seen_nxt = seen_r + 2'd1;
        end else begin
          npos_nxt = npos_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (insert) begin
      s1_v_nxt = 1'b1;
    end else if (s1_take) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      seen_r <= '0;
      npos_r <= '0;
      s1_v_r <= 1'b0;
    end else begin
      hist_r <= hist_nxt;
      seen_r <= seen_nxt;
      npos_r <= npos_nxt;
      s1_v_r <= s1_v_nxt;
    end
  end

  // low 32 bits of the product, registered before the shift
  always_ff @(posedge clk) begin
    if (insert) begin
      prod_r <= word * dhci_pkg::HASH_MULT;
      pos_r  <= npos_r;
    end
  end

  assign s1_valid = s1_v_r;
  assign s1_prod  = prod_r;
  assign s1_pos   = pos_r;

endmodule

### rtl/dhci_head_mem.sv
// head table: synchronous ram, one write and one registered read port,
// swept to zero after reset; no package dependency
module dhci_head_mem #(
  parameter int ADDR_W = 15,
  parameter int DATA_W = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  output logic              clearing
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rd_data_r;
  logic              clr_busy_r, clr_busy_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [DATA_W-1:0] wd;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (&clr_addr_r) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  assign we = clr_busy_r || wr_en;
  assign wa = clr_busy_r ? clr_addr_r : wr_addr;
  assign wd = clr_busy_r ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clr_busy_r;

endmodule

### rtl/dhci_chain_mem.sv
// chain table: write-only link store, contents undefined until written
// no package dependency
module dhci_chain_mem #(
  parameter int ADDR_W = 15,
  parameter int DATA_W = 15
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

### rtl/deflate_hash_chain_insert_unit.sv
// Hash chain inserter for a deflate match finder. Bytes enter on in_if one
// per item; from the fourth byte of a buffer on, each byte completes a
// little-endian word that is hashed (multiply by 0x1E35A7BD, keep the top
// hash_width bits) and linked in: the chain entry at the word's position gets
// the old head entry and the head entry gets the position. Each insertion
// gives one item on out_if; the start byte and the next two give none. The
// unit takes one byte per cycle when the result side keeps up; an inserting
// byte loads the multiply register, then issues the head ram read as it moves
// to stage 2, then loads the output register, and each step waits while the
// next is full. After reset the head ram is swept to zero, one entry a cycle,
// and in_if.ready stays low until the sweep ends; cfg writes are taken during
// the sweep. The user is to write hash_width through cfg_we/cfg_wdata only
// while the unit is idle; the unit itself does not enforce this. Values below 8
// act as 8, values above min(HEAD_BITS,15) act as that bound.
// depends on dhci_pkg, dhci_in_if, dhci_out_if, dhci_front, dhci_head_mem,
// dhci_chain_mem
module deflate_hash_chain_insert_unit #(
  parameter int WINDOW_BITS = 15,
  parameter int HEAD_BITS   = 15
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  dhci_pkg::hw_t   cfg_wdata,
  dhci_in_if.sink         in_if,
  dhci_out_if.source      out_if
);

  // widest hash the head table can index
  localparam int HwTop = (HEAD_BITS < 15) ? HEAD_BITS : 15;

  // configuration
  dhci_pkg::hw_t          hw_r;
  dhci_pkg::hw_t          hw_eff;

  // stage 1: product and position from the front end
  logic                   s1_valid;
  dhci_pkg::word_t        s1_prod;
  logic [WINDOW_BITS-1:0] s1_pos;
  logic                   s1_take;
  logic [5:0]             shamt;
  dhci_pkg::word_t        shifted;
  logic [HEAD_BITS-1:0]   head_addr;

  // stage 2: head read in flight, resolved and written back on s2_go
  logic                   s2_v_r, s2_v_nxt;
  logic [HEAD_BITS-1:0]   s2_addr_r;
  dhci_pkg::field_t       s2_hash_r;
  logic [WINDOW_BITS-1:0] s2_pos_r;
  logic                   s2_go;
  logic                   fwd_hit_r;
  logic [WINDOW_BITS-1:0] fwd_data_r;
  logic [WINDOW_BITS-1:0] head_rd_data;
  logic [WINDOW_BITS-1:0] old_head;
  logic                   head_clearing;

  // output register
  logic                   out_v_r, out_v_nxt;
  dhci_pkg::field_t       out_pos_r;
  dhci_pkg::field_t       out_hash_r;
  dhci_pkg::field_t       out_prior_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r <= dhci_pkg::HW_RESET;
    end else if (cfg_we) begin
      hw_r <= cfg_wdata;
    end
  end

  // clamp the hash width to at least 8 and to what the head table supports
  always_comb begin
    if (hw_r < dhci_pkg::HW_MIN) begin
      hw_eff = dhci_pkg::HW_MIN;
    end else if (32'(hw_r) > HwTop) begin
      hw_eff = dhci_pkg::hw_t'(HwTop);
    end else begin
      hw_eff = hw_r;
    end
  end

  // handshake chain: output register, then stage 2, then stage 1
  assign s2_go   = s2_v_r && (!out_v_r || out_if.ready);
  assign s1_take = s1_valid && (!s2_v_r || s2_go);

  dhci_front #(
    .WINDOW_BITS (WINDOW_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .s1_take  (s1_take),
    .s1_block (head_clearing),
    .s1_valid (s1_valid),
    .s1_prod  (s1_prod),
    .s1_pos   (s1_pos)
  );

  // top hw_eff bits of the product; never wider than the head address
  assign shamt     = 6'd32 - {2'b00, hw_eff};
  assign shifted   = s1_prod >> shamt;
  assign head_addr = shifted[HEAD_BITS-1:0];

  // a head write landing on the edge that issues the read is not seen by the
  // ram read, so catch it here and use it instead of the read data
  always_ff @(posedge clk) begin
    if (s1_take) begin
      fwd_hit_r  <= s2_go && (s2_addr_r == head_addr);
      fwd_data_r <= s2_pos_r;
      s2_addr_r  <= head_addr;
      s2_hash_r  <= shifted[dhci_pkg::FIELD_W-1:0];
      s2_pos_r   <= s1_pos;
    end
  end

  always_comb begin
    s2_v_nxt = s2_v_r;
    if (s1_take) begin
      s2_v_nxt = 1'b1;
    end else if (s2_go) begin
      s2_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s2_v_nxt;
    end
  end

  assign old_head = fwd_hit_r ? fwd_data_r : head_rd_data;

  dhci_head_mem #(
    .ADDR_W (HEAD_BITS),
    .DATA_W (WINDOW_BITS)
  ) u_head (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (s1_take),
    .rd_addr  (head_addr),
    .rd_data  (head_rd_data),
    .wr_en    (s2_go),
    .wr_addr  (s2_addr_r),
    .wr_data  (s2_pos_r),
    .clearing (head_clearing)
  );

  dhci_chain_mem #(
    .ADDR_W (WINDOW_BITS),
    .DATA_W (WINDOW_BITS)
  ) u_chain (
    .clk     (clk),
    .wr_en   (s2_go),
    .wr_addr (s2_pos_r),
    .wr_data (old_head)
  );

  always_comb begin
    out_v_nxt = out_v_r;
    if (s2_go) begin
      out_v_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_pos_r   <= dhci_pkg::field_t'(s2_pos_r);
      out_hash_r  <= s2_hash_r;
      out_prior_r <= dhci_pkg::field_t'(old_head);
    end
  end

  assign out_if.valid      = out_v_r;
  assign out_if.position   = out_pos_r;
  assign out_if.hash_value = out_hash_r;
  assign out_if.prior_head = out_prior_r;

  // no byte may enter while the head table is being swept
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    head_clearing |-> !in_if.ready)
    else $error("byte taken during head table sweep");

  // same-address write on the read edge must be forwarded
  a_fwd_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_take && s2_go && (s2_addr_r == head_addr)) |=> fwd_hit_r)
    else $error("head write on read edge not forwarded");

  // a pending lookup is never dropped
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !s2_go) |=> (s2_v_r && $stable(s2_pos_r) && $stable(s2_addr_r)))
    else $error("stalled head lookup lost");

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for deflate_hash_chain_insert_unit: byte items in, link items out
// depends on dhci_pkg, dhci_in_if, dhci_out_if and the unit's rtl
module tb_top;

  localparam int WIN_BITS      = 15;
  localparam int HEAD_BITS     = 15;
  localparam int HEAD_ENTRIES  = 1 << HEAD_BITS;
  // margin for the pipeline to drain after the last link
  localparam int DRAIN_CYCLES  = 8;
  // the head sweep after reset holds ready low; the limit leaves room for it
  localparam int WATCHDOG_LIMIT = 4 * HEAD_ENTRIES + 2000;
  localparam int MAX_PRINTED   = 40;
  localparam dhci_pkg::byte_t NARROW_SET [4] = '{8'h00, 8'hFF, 8'h41, 8'h42};

  typedef struct packed {
    dhci_pkg::byte_t data;
    logic            sob;
  } buf_byte_t;

  typedef struct packed {
    dhci_pkg::field_t position;
    dhci_pkg::field_t hash_value;
    dhci_pkg::field_t prior_head;
  } link_t;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          cfg_we;
  dhci_pkg::hw_t cfg_wdata;

  dhci_in_if  in_if ();
  dhci_out_if out_if ();

  deflate_hash_chain_insert_unit #(
    .WINDOW_BITS (WIN_BITS),
    .HEAD_BITS   (HEAD_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_if),
    .out_if    (out_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  buf_byte_t byte_queue[$];
  link_t     pending_links[$];
  buf_byte_t drive_item;
  int        src_gap;
  int        sink_gap;
  int        idle_cycles;
  int        fail_count;
  bit        idle_on;

  // predictor state
  dhci_pkg::hw_t      hash_width_cfg;
  dhci_pkg::history_t hist;
  dhci_pkg::seen_t    seen;
  dhci_pkg::field_t   next_pos;
  dhci_pkg::field_t   head_mem [HEAD_ENTRIES];

  function automatic int hash_bits_in_use();
    int w;
    int top;
    w   = int'(hash_width_cfg);
    top = (HEAD_BITS < 15) ? HEAD_BITS : 15;
    if (w < int'(dhci_pkg::HW_MIN)) w = int'(dhci_pkg::HW_MIN);
    if (w > top) w = top;
    return w;
  endfunction

  // advance the byte history and link in the completed word, if any
  function automatic void link_byte(input dhci_pkg::byte_t b, input logic sob);
    dhci_pkg::word_t  word;
    dhci_pkg::word_t  product;
    dhci_pkg::field_t h;
    link_t            lnk;
    if (sob) begin
      hist     = {b, 16'h0000};
      seen     = 2'd1;
      next_pos = '0;
      return;
    end
    if (seen < dhci_pkg::SEEN_FULL) begin
      hist = {b, hist[23:8]};
      seen = seen + 2'd1;
      return;
    end
    word    = {b, hist};
    product = word * dhci_pkg::HASH_MULT;
    h       = dhci_pkg::field_t'((product >> (32 - hash_bits_in_use())) & (HEAD_ENTRIES - 1));
    lnk.position   = next_pos;
    lnk.hash_value = h;
    lnk.prior_head = head_mem[h];
    head_mem[h]    = next_pos;
    next_pos       = next_pos + 1'b1;
    hist           = word[31:8];
    pending_links.push_back(lnk);
  endfunction

  task automatic report_mismatch(input string what, input dhci_pkg::field_t got,
                                 input dhci_pkg::field_t want);
    fail_count++;
    if (fail_count <= MAX_PRINTED)
      $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  task automatic check_link();
    link_t want;
    if (pending_links.size() == 0) begin
      report_mismatch("result with none pending", out_if.position, 'x);
      return;
    end
    want = pending_links.pop_front();
    if (out_if.position !== want.position)
      report_mismatch("position", out_if.position, want.position);
    if (out_if.hash_value !== want.hash_value)
      report_mismatch("hash_value", out_if.hash_value, want.hash_value);
    if (out_if.prior_head !== want.prior_head)
      report_mismatch("prior_head", out_if.prior_head, want.prior_head);
  endtask

  // byte driver: items come from byte_queue, predicted on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        link_byte(in_if.data_byte, in_if.start_of_buffer);
      end
      if (in_if.valid && !in_if.ready) begin
        // stalled item stays on the bus
      end else if (src_gap > 0) begin
        src_gap--;
        in_if.valid <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        drive_item = byte_queue.pop_front();
        in_if.valid           <= 1'b1;
        in_if.data_byte       <= drive_item.data;
        in_if.start_of_buffer <= drive_item.sob;
        if (idle_on && $urandom_range(0, 15) == 0) src_gap = $urandom_range(1, 4);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // link monitor with random back-pressure while idle_on is set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) check_link();
      if (sink_gap > 0) begin
        sink_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 11) == 0) sink_gap = $urandom_range(1, 4);
      end
    end
  end

  // cycles without any handshake; the reset sweep is the longest legal stretch
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic queue_byte(input dhci_pkg::byte_t b, input logic sob);
    buf_byte_t pb;
    pb.data = b;
    pb.sob  = sob;
    byte_queue.push_back(pb);
  endtask

  // mostly whole buffers with random content, some stray start marks
  task automatic queue_buffers(input int n_bytes);
    int left;
    int len;
    int k;
    bit narrow;
    dhci_pkg::byte_t b;
    left = n_bytes;
    while (left > 0) begin
      len    = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 160) : $urandom_range(1, 24);
      narrow = 1'($urandom_range(0, 1));
      for (k = 0; k < len && left > 0; k++) begin
        b = narrow ? NARROW_SET[$urandom_range(0, 3)] : dhci_pkg::byte_t'($urandom_range(0, 255));
        queue_byte(b, (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0));
        left--;
      end
    end
  endtask

  // one long buffer with no stray start marks
  task automatic queue_long_buffer(input int n_bytes);
    int k;
    queue_byte(dhci_pkg::byte_t'($urandom_range(0, 255)), 1'b1);
    for (k = 1; k < n_bytes; k++) begin
      if ($urandom_range(0, 1) == 0) queue_byte(NARROW_SET[$urandom_range(0, 3)], 1'b0);
      else queue_byte(dhci_pkg::byte_t'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // everything accepted, every link delivered, then let the pipe settle;
  // sampled on the falling edge so the driver's updates are already visible
  task automatic wait_idle();
    @(negedge clk);
    while (byte_queue.size() != 0 || in_if.valid || pending_links.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_hash_width(input dhci_pkg::hw_t v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we         <= 1'b0;
    hash_width_cfg = v;
  endtask

  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    in_if.valid           = 1'b0;
    in_if.data_byte       = '0;
    in_if.start_of_buffer = 1'b0;
    out_if.ready          = 1'b0;
    src_gap        = 0;
    sink_gap       = 0;
    idle_cycles    = 0;
    fail_count     = 0;
    idle_on        = 1'b1;
    hash_width_cfg = dhci_pkg::HW_RESET;
    hist           = '0;
    seen           = '0;
    next_pos       = '0;
    foreach (head_mem[i]) head_mem[i] = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // bytes before any start mark form the first buffer
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    // restart: all-zero word again links back to the first insertion
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    // start mark before a word completes, then back-to-back start marks
    queue_byte(8'h11, 1'b1);
    queue_byte(8'h22, 1'b0);
    queue_byte(8'h33, 1'b1);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'hFE, 1'b0);
    queue_byte(8'hFF, 1'b0);
    wait_idle();

    // width below the legal range acts as the minimum
    write_hash_width(4'd0);
    queue_buffers(250);
    wait_idle();

    write_hash_width(4'd8);
    queue_buffers(200);
    wait_idle();

    write_hash_width(4'd11);
    queue_buffers(200);
    wait_idle();

    write_hash_width(4'd5);
    queue_buffers(150);
    wait_idle();

    write_hash_width(4'd12);
    queue_long_buffer(200);
    wait_idle();

    // closing stretch runs at full rate on both sides
    write_hash_width(4'd15);
    idle_on = 1'b0;
    queue_buffers(200);
    wait_idle();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
